// ===== rtl/dttm_pkg.sv =====
package dttm_pkg;

  // Default number of fraction digits in the fixed-point result.
  localparam int unsigned FRACTION_DIGITS_DEF = 6;

  // Widths of the value path and of the padding count (holds up to fifteen).
  localparam int unsigned ACC_W = 64;
  localparam int unsigned PAD_W = 4;

  // Character codes the scanner recognizes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  // A finished token on its way through the padding pipeline.
  // acc is kept at zero whenever good is low.
  typedef struct packed {
    logic             good;
    logic [PAD_W-1:0] pads;
    logic [ACC_W-1:0] acc;
  } tok_t;

endpackage

// ===== rtl/dttm_scan.sv =====
module dttm_scan #(
  parameter int unsigned FRACTION_DIGITS = dttm_pkg::FRACTION_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic [0:0]        in_tuser,
  input  logic              in_tlast,
  output logic              tok_valid,
  input  logic              tok_ready,
  output dttm_pkg::tok_t    tok
);

  localparam int unsigned CntW = (FRACTION_DIGITS < 1) ? 1 : $clog2(FRACTION_DIGITS + 1);

  logic [dttm_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                       point_r, point_nxt;
  logic                       digit_r, digit_nxt;
  logic                       failed_r, failed_nxt;
  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic                       tok_valid_r, tok_valid_nxt;
  dttm_pkg::tok_t             tok_r, tok_nxt;

  logic                       accept;
  logic                       is_digit;
  logic [7:0]                 dig_diff;
  logic [3:0]                 digit;
  logic [dttm_pkg::ACC_W+3:0] shifted;
  logic                       skip_digit;

  // The token register frees up when it is empty or its transfer completes.
  assign in_tready = !tok_valid_r || tok_ready;
  assign accept    = in_tvalid && in_tready;

  assign is_digit = in_tdata inside {[dttm_pkg::CHAR_ZERO:dttm_pkg::CHAR_NINE]};
  assign dig_diff = in_tdata - dttm_pkg::CHAR_ZERO;
  assign digit    = dig_diff[3:0];

  // Accumulator times ten plus the digit, wide enough to see any overflow.
  assign shifted = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                 + {{dttm_pkg::ACC_W{1'b0}}, digit};

  // Fraction digits past the kept precision are checked and then dropped.
  assign skip_digit = point_r && (cnt_r >= CntW'(FRACTION_DIGITS));

  // Token state update for one accepted character.
  always_comb begin
    acc_nxt    = acc_r;
    point_nxt  = point_r;
    digit_nxt  = digit_r;
    failed_nxt = failed_r;
    cnt_nxt    = cnt_r;
    if (accept && in_tuser[0] && !failed_r) begin
      if (is_digit) begin
        digit_nxt = 1'b1;
        if (!skip_digit) begin
          if (point_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (shifted[dttm_pkg::ACC_W+3:dttm_pkg::ACC_W] != 4'b0) begin
            failed_nxt = 1'b1;
          end else begin
            acc_nxt = shifted[dttm_pkg::ACC_W-1:0];
          end
        end
      end else if (in_tdata == dttm_pkg::CHAR_POINT) begin
        if (point_r) begin
          failed_nxt = 1'b1;
        end else begin
          point_nxt = 1'b1;
        end
      end else begin
        failed_nxt = 1'b1;
      end
    end
  end

  // On the last character, hand the token to the padding stages.
  always_comb begin
    tok_valid_nxt = tok_valid_r;
    tok_nxt       = tok_r;
    if (in_tready) begin
      tok_valid_nxt = accept && in_tlast;
    end
    if (accept && in_tlast) begin
      tok_nxt.good = !failed_nxt && digit_nxt;
      tok_nxt.acc  = tok_nxt.good ? acc_nxt : '0;
      tok_nxt.pads = dttm_pkg::PAD_W'(FRACTION_DIGITS) - dttm_pkg::PAD_W'(cnt_nxt);
    end
  end

  // State registers; the token state clears after every last character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      point_r     <= 1'b0;
      digit_r     <= 1'b0;
      failed_r    <= 1'b0;
      cnt_r       <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
      if (accept && in_tlast) begin
        acc_r    <= '0;
        point_r  <= 1'b0;
        digit_r  <= 1'b0;
        failed_r <= 1'b0;
        cnt_r    <= '0;
      end else begin
        acc_r    <= acc_nxt;
        point_r  <= point_nxt;
        digit_r  <= digit_nxt;
        failed_r <= failed_nxt;
        cnt_r    <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_valid = tok_valid_r;
  assign tok       = tok_r;

  // The token state is clean after a last character has been taken.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (acc_r == '0 && !point_r && !digit_r && !failed_r && cnt_r == '0))
    else $error("token state not cleared after last character");

  // The kept fraction count never passes the configured precision.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(FRACTION_DIGITS))
    else $error("fraction count beyond precision");

  // An error sticks until the token ends.
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !(accept && in_tlast)) |=> failed_r)
    else $error("error flag dropped inside a token");

endmodule

// ===== rtl/dttm_pad_stage.sv =====
module dttm_pad_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  dttm_pkg::tok_t up_tok,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dttm_pkg::tok_t dn_tok
);

  logic                       vld_r, vld_nxt;
  dttm_pkg::tok_t             tok_r, tok_nxt;
  logic [dttm_pkg::ACC_W+3:0] prod;

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  // One padding digit: multiply by ten while pads remain, flag overflow.
  assign prod = ({4'b0, up_tok.acc} << 3) + ({4'b0, up_tok.acc} << 1);

  always_comb begin
    tok_nxt = up_tok;
    if (up_tok.good && up_tok.pads != '0) begin
      tok_nxt.pads = up_tok.pads - 1'b1;
      if (prod[dttm_pkg::ACC_W+3:dttm_pkg::ACC_W] != 4'b0) begin
        tok_nxt.good = 1'b0;
        tok_nxt.acc  = '0;
      end else begin
        tok_nxt.acc = prod[dttm_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_tok   = tok_r;

endmodule

// ===== rtl/decimal_text_to_millionths.sv =====
// After its last character is transferred, a result passes the token register and then
// one register per padding stage. Throughput: one character per cycle, and a result per
// cycle when tokens are one character, both while out_tready does not stall the pipeline.
// Each padding stage multiplies by ten at most once, so padding flows down the pipeline.
// Reset (synchronous, rst_n low) clears the token state and empties the pipeline.
module decimal_text_to_millionths #(
  parameter int unsigned FRACTION_DIGITS = dttm_pkg::FRACTION_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [0:0]  in_tuser,   // [0] has_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value_millionths
  output logic [0:0]  out_tuser   // [0] ok
);

  dttm_pkg::tok_t stg       [0:FRACTION_DIGITS];
  logic           stg_valid [0:FRACTION_DIGITS];
  logic           stg_ready [0:FRACTION_DIGITS];

  // Character scanner and token register.
  dttm_scan #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .tok_valid (stg_valid[0]),
    .tok_ready (stg_ready[0]),
    .tok       (stg[0])
  );

  // Padding pipeline, at most one multiply by ten per stage.
  for (genvar i = 0; i < FRACTION_DIGITS; i++) begin : g_pad
    dttm_pad_stage u_pad (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_ready (stg_ready[i]),
      .up_tok   (stg[i]),
      .dn_valid (stg_valid[i+1]),
      .dn_ready (stg_ready[i+1]),
      .dn_tok   (stg[i+1])
    );
  end

  // The last stage register drives the result channel.
  assign stg_ready[FRACTION_DIGITS] = out_tready;
  assign out_tvalid   = stg_valid[FRACTION_DIGITS];
  assign out_tdata    = stg[FRACTION_DIGITS].acc;
  assign out_tuser[0] = stg[FRACTION_DIGITS].good;

  // A failed token always reports a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 64'd0))
    else $error("failed token with nonzero value");

endmodule
